// ----- hw/rtl/rfor_pkg.sv -----
// ----------------------------------------------------------------------------
// rfor_pkg
// shared constants, types and helpers of the rectangle rasterizer
// ----------------------------------------------------------------------------
package rfor_pkg;

  localparam int MAX_DIM   = 256;
  localparam int FRAC_BITS = 8;

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CFG_W   = DIM_W + 1;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int FIX_W   = 24;
  localparam int COORD_W = FIX_W + 3;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // rectangle kinds
  localparam logic [7:0] KIND_FILLED  = 8'h52;
  localparam logic [7:0] KIND_OUTLINE = 8'h72;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(MAX_DIM);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(MAX_DIM);
  localparam logic [7:0]       BG_RST     = 8'd32;

  localparam logic signed [COORD_W-1:0] ONE_FIX = COORD_W'(1) <<< FRAC_BITS;

  // rectangle bounds, all in canvas fixed point
  typedef struct packed {
    logic                      filled;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] x0p1;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] x1m1;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y0p1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] y1m1;
  } rfor_rect_t;

  // dimension register clamped to the store size
  function automatic logic [CFG_W-1:0] used_dim(input logic [CFG_W-1:0] v);
    used_dim = (v > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : v;
  endfunction

endpackage

// ----- hw/rtl/rfor_cover.sv -----
// ----------------------------------------------------------------------------
// rfor_cover
// decides whether one pixel of the sweep is painted by the current rectangle
// ----------------------------------------------------------------------------
module rfor_cover (
  input  logic [rfor_pkg::DIM_W-1:0] col,
  input  logic [rfor_pkg::DIM_W-1:0] row,
  input  rfor_pkg::rfor_rect_t       rect,
  output logic                       hit
);
  import rfor_pkg::*;

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic                      covered;
  logic                      near_edge;

  // pixel centers sit on integer points
  assign px = COORD_W'(col) <<< FRAC_BITS;
  assign py = COORD_W'(row) <<< FRAC_BITS;

  assign covered = (px >= rect.x0) && (px <= rect.x1) &&
                   (py >= rect.y0) && (py <= rect.y1);

  // less than one unit from some edge
  assign near_edge = (px < rect.x0p1) || (px > rect.x1m1) ||
                     (py < rect.y0p1) || (py > rect.y1m1);

  assign hit = covered && (near_edge || rect.filled);

endmodule

// ----- hw/rtl/rect_fill_outline_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// rect_fill_outline_rasterizer_top
// character frame store with clear, rectangle draw and cell read commands
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   ------------------------   ------------------------------------
//   command   start / busy               in_cmd, in_kind, in_rect_*, in_color,
//                                        in_col, in_row
//   result    out_valid (one-cycle)      out_status, out_pixel
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// clear and draw sweep the canvas in use one cell per cycle through the
// single write port of the frame store
// read goes through a registered memory read, then the result register
// rejected rectangles, unused commands and an empty canvas answer next cycle
// rst_n is synchronous; the frame store is not cleared by reset
// the result strobe lasts one cycle and cannot be held off by the receiver
//
module rect_fill_outline_rasterizer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command transfer
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic [7:0]                           in_kind,
  input  logic signed [rfor_pkg::FIX_W-1:0]    in_rect_x,
  input  logic signed [rfor_pkg::FIX_W-1:0]    in_rect_y,
  input  logic signed [rfor_pkg::FIX_W-1:0]    in_rect_width,
  input  logic signed [rfor_pkg::FIX_W-1:0]    in_rect_height,
  input  logic [7:0]                           in_color,
  input  logic [7:0]                           in_col,
  input  logic [7:0]                           in_row,
  // result transfer
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic [7:0]                           out_pixel,
  // configuration transfer
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [rfor_pkg::CFG_W-1:0]           cfg_data
);
  import rfor_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;

  // configuration registers
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [7:0]       bg_r;
  logic [CFG_W-1:0] w_used;
  logic [CFG_W-1:0] h_used;

  // control
  logic [1:0]       state_r,      state_nxt;
  logic             clear_r,      clear_nxt;
  logic [DIM_W-1:0] col_r,        col_nxt;
  logic [DIM_W-1:0] row_r,        row_nxt;
  logic             out_valid_r,  out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [7:0]       out_pixel_r,  out_pixel_nxt;

  // payload
  rfor_rect_t       rect_r,       rect_nxt;
  logic [7:0]       wdata_r,      wdata_nxt;
  logic             rd_ok_r,      rd_ok_nxt;

  // frame store
  logic [7:0]       mem [MAX_DIM*MAX_DIM];
  logic [7:0]       rd_data_r;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic             accept;
  logic             hit;
  logic             last_col;
  logic             last_row;
  logic             bad_rect;
  logic             canvas_empty;

  logic signed [COORD_W-1:0] x0_s, y0_s, x1_s, y1_s;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pixel  = out_pixel_r;

  assign w_used       = used_dim(width_r);
  assign h_used       = used_dim(height_r);
  assign canvas_empty = (w_used == '0) || (h_used == '0);

  // rectangle checks and bounds, formed at the command transfer
  assign bad_rect = in_rect_width[FIX_W-1]  || (in_rect_width  == '0) ||
                    in_rect_height[FIX_W-1] || (in_rect_height == '0) ||
                    ((in_kind != KIND_FILLED) && (in_kind != KIND_OUTLINE));

  assign x0_s = COORD_W'(in_rect_x);
  assign y0_s = COORD_W'(in_rect_y);
  assign x1_s = x0_s + COORD_W'(in_rect_width);
  assign y1_s = y0_s + COORD_W'(in_rect_height);

  // sweep position
  assign last_col = ({1'b0, col_r} == (w_used - CFG_W'(1)));
  assign last_row = ({1'b0, row_r} == (h_used - CFG_W'(1)));

  rfor_cover u_cover (
    .col  (col_r),
    .row  (row_r),
    .rect (rect_r),
    .hit  (hit)
  );

  assign wr_addr = {row_r, col_r};
  assign mem_we  = (state_r == ST_SWEEP) && (clear_r || hit);
  assign rd_addr = {in_row[DIM_W-1:0], in_col[DIM_W-1:0]};
  assign mem_re  = accept && (in_cmd == CMD_READ);

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      bg_r     <= BG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_BG:     bg_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    clear_nxt      = clear_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    rect_nxt       = rect_r;
    wdata_nxt      = wdata_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = 1'b0;
    out_pixel_nxt  = 8'd0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          col_nxt = '0;
          row_nxt = '0;
          case (in_cmd)
            CMD_CLEAR: begin
              clear_nxt = 1'b1;
              wdata_nxt = bg_r;
              if (canvas_empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            CMD_DRAW: begin
              clear_nxt      = 1'b0;
              wdata_nxt      = in_color;
              rect_nxt.filled = (in_kind == KIND_FILLED);
              rect_nxt.x0    = x0_s;
              rect_nxt.x0p1  = x0_s + ONE_FIX;
              rect_nxt.x1    = x1_s;
              rect_nxt.x1m1  = x1_s - ONE_FIX;
              rect_nxt.y0    = y0_s;
              rect_nxt.y0p1  = y0_s + ONE_FIX;
              rect_nxt.y1    = y1_s;
              rect_nxt.y1m1  = y1_s - ONE_FIX;
              if (bad_rect) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end else if (canvas_empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            CMD_READ: begin
              // cells outside the canvas in use read as zero
              rd_ok_nxt = ({1'b0, in_col} < w_used) && ({1'b0, in_row} < h_used);
              state_nxt = ST_RDWAIT;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            row_nxt = row_r + DIM_W'(1);
          end
        end else begin
          col_nxt = col_r + DIM_W'(1);
        end
      end
      ST_RDWAIT: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_pixel_nxt = rd_ok_r ? rd_data_r : 8'd0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clear_r     <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clear_r     <= clear_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rect_r       <= rect_nxt;
    wdata_r      <= wdata_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_status_r <= out_status_nxt;
    out_pixel_r  <= out_pixel_nxt;
  end

endmodule

// ----- hw/rtl/rfor_chk.sv -----
// ----------------------------------------------------------------------------
// rfor_chk
// port-level checks of the rectangle rasterizer, bound to the top level
// ----------------------------------------------------------------------------
module rfor_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_cmd,
  input logic [7:0] in_kind,
  input logic       out_valid,
  input logic       out_status,
  input logic [7:0] out_pixel
);
  import rfor_pkg::*;

  // a result only follows an accepted command or the end of busy work
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a command behind it");

  // a rejected rectangle carries no pixel
  a_rej_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_pixel == 8'd0))
    else $error("rejected result with nonzero pixel");

  // unknown kind answers at once with the reject status
  a_bad_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_DRAW) &&
     (in_kind != KIND_FILLED) && (in_kind != KIND_OUTLINE))
    |=> (out_valid && out_status && !busy))
    else $error("unknown kind not rejected");

  // a read holds the block for the memory access
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_READ)) |=> (busy && !out_valid))
    else $error("read did not wait for the frame store");

endmodule

bind rect_fill_outline_rasterizer_top rfor_chk u_rfor_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_cmd     (in_cmd),
  .in_kind    (in_kind),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_pixel  (out_pixel)
);
